// ===== design/fbh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbh_pkg
// shared constants, codes and types of the first/best fit heap allocator
// ----------------------------------------------------------------------------
package fbh_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam int MAX_BLOCKS_DEF = 64;

	localparam int FIELD_W     = 17;
	localparam int HDR_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int ALIGN_BYTES = 8;
	localparam int HDR_MIN     = 8;
	localparam int HDR_RESET   = 48;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic FIT_FIRST = 1'b0;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 2'd1;

	typedef struct packed {
		logic idle;
		logic res_valid;
		logic res_ok;
	} eng_stat_t;

endpackage
`default_nettype wire

// ===== design/fbh_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbh_table
// block table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fbh_table #(
	parameter int DEPTH = 64,
	parameter int DW    = 35
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DW-1:0]            rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DW-1:0]            wr_data
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== design/fbh_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbh_engine
// table scan, split, append, merge and shift sequencer around the block table
// ----------------------------------------------------------------------------
module fbh_engine #(
	parameter int HEAP_BYTES = fbh_pkg::HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS = fbh_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  opcode,
	input  wire logic [fbh_pkg::FIELD_W-1:0]           request_bytes,
	input  wire logic [fbh_pkg::FIELD_W-1:0]           release_address,
	input  wire logic                                  fit_mode,
	input  wire logic [fbh_pkg::HDR_W-1:0]             hdr,
	input  wire logic                                  res_take,
	output fbh_pkg::eng_stat_t                         stat,
	output logic      [$clog2(HEAP_BYTES+1)-1:0]       payload_address,
	output logic      [$clog2(HEAP_BYTES+1)-1:0]       segment_bytes,
	output logic      [$clog2(HEAP_BYTES+1)-1:0]       free_bytes
);
	import fbh_pkg::*;

	localparam int AW   = $clog2(HEAP_BYTES + 1);
	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int CW   = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
	localparam int DW   = 2 * AW + 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SCAN  = 8'b0000_0010,
		ST_FOUND = 8'b0000_0100,
		ST_SHUP  = 8'b0000_1000,
		ST_WRNEW = 8'b0001_0000,
		ST_FNXT  = 8'b0010_0000,
		ST_SHDN  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic            op_q;
	logic [CW-1:0]   sz_q;
	logic [FIELD_W-1:0] rel_q;
	logic [CNTW-1:0] count_q;
	logic [AW-1:0]   seg_q;
	logic [AW-1:0]   ft_q;
	logic [CNTW-1:0] rptr_q;
	logic            dv_s1;
	logic [CNTW-1:0] didx_s1;
	logic            found_q;
	logic [CNTW-1:0] bidx_q;
	logic [AW-1:0]   boff_q;
	logic [AW-1:0]   bsize_q;
	logic [AW-1:0]   bleft_q;
	logic [DW-1:0]   prev_q;
	logic [DW-1:0]   cur_q;
	logic [CNTW-1:0] cidx_q;
	logic [1:0]      d_q;
	logic [DW-1:0]   new_q;
	logic            ok_q;
	logic [AW-1:0]   addr_q;

	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic [DW-1:0]   rd_data;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic [DW-1:0]   wr_data;

	// fields of the entry coming out of the table
	logic [AW-1:0]   e_off;
	logic [AW-1:0]   e_size;
	logic            e_free;
	logic            hit_a;
	logic [AW-1:0]   left_a;
	logic            hit_f;

	logic [CW-1:0]   sz_round;
	logic [AW-1:0]   left;
	logic            split;
	logic            append_ok;
	logic [CW-1:0]   hdr_c;

	logic            nf;
	logic            pf;
	logic [CW-1:0]   merged;
	logic [CW-1:0]   pmerged;
	logic [CW-1:0]   ft_free;
	logic [CNTW-1:0] up_addr;
	logic [CNTW-1:0] dn_addr;
	logic [CNTW-1:0] new_addr;

	fbh_table #(
		.DEPTH (MAX_BLOCKS),
		.DW    (DW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign hdr_c    = CW'(hdr);
	assign sz_round = (CW'(request_bytes) + CW'(ALIGN_BYTES - 1)) & ~CW'(ALIGN_BYTES - 1);

	assign e_off  = rd_data[DW-1 -: AW];
	assign e_size = rd_data[AW:1];
	assign e_free = rd_data[0];
	assign hit_a  = e_free && (CW'(e_size) >= sz_q);
	assign left_a = AW'(CW'(e_size) - sz_q);
	assign hit_f  = CW'(e_off) == CW'(rel_q);

	assign left      = bsize_q - AW'(sz_q);
	assign split     = (CW'(left) > hdr_c) && (count_q < CNTW'(MAX_BLOCKS));
	assign append_ok = (count_q < CNTW'(MAX_BLOCKS))
		&& (CW'(seg_q) + hdr_c + sz_q <= CW'(HEAP_BYTES));

	// merge arithmetic: entry i, its successor (still in the read register) and predecessor
	assign nf      = dv_s1 && e_free;
	assign pf      = (cidx_q != '0) && prev_q[0];
	assign merged  = CW'(cur_q[AW:1]) + (nf ? hdr_c + CW'(e_size) : '0);
	assign pmerged = CW'(prev_q[AW:1]) + hdr_c + merged;
	assign ft_free = CW'(ft_q) + (cur_q[0] ? '0 : CW'(cur_q[AW:1]))
		+ (nf ? hdr_c : '0) + (pf ? hdr_c : '0);

	assign up_addr  = didx_s1 + CNTW'(1);
	assign dn_addr  = didx_s1 - CNTW'(d_q);
	assign new_addr = bidx_q + CNTW'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rptr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_SCAN: begin
				rd_en = rptr_q < count_q;
			end
			ST_FOUND: begin
				if (found_q) begin
					wr_en   = 1'b1;
					wr_addr = bidx_q[IW-1:0];
					wr_data = {boff_q, (split ? AW'(sz_q) : bsize_q), 1'b0};
				end else if (append_ok) begin
					wr_en   = 1'b1;
					wr_addr = count_q[IW-1:0];
					wr_data = {AW'(CW'(seg_q) + hdr_c), AW'(sz_q), 1'b0};
				end
			end
			ST_SHUP: begin
				rd_en   = rptr_q > bidx_q;
				wr_en   = dv_s1;
				wr_addr = up_addr[IW-1:0];
				wr_data = rd_data;
			end
			ST_WRNEW: begin
				wr_en   = 1'b1;
				wr_addr = new_addr[IW-1:0];
				wr_data = new_q;
			end
			ST_FNXT: begin
				wr_en = 1'b1;
				if (pf) begin
					wr_addr = IW'(cidx_q - CNTW'(1));
					wr_data = {prev_q[DW-1 -: AW], AW'(pmerged), 1'b1};
				end else begin
					wr_addr = cidx_q[IW-1:0];
					wr_data = {cur_q[DW-1 -: AW], AW'(merged), 1'b1};
				end
			end
			ST_SHDN: begin
				rd_en   = rptr_q < count_q;
				wr_en   = dv_s1;
				wr_addr = dn_addr[IW-1:0];
				wr_data = rd_data;
			end
			ST_IDLE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			seg_q   <= '0;
			ft_q    <= '0;
			dv_s1   <= 1'b0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			addr_q  <= '0;
		end else begin
			dv_s1   <= rd_en;
			didx_s1 <= rptr_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						sz_q    <= sz_round;
						rel_q   <= release_address;
						found_q <= 1'b0;
						rptr_q  <= '0;
						bidx_q  <= '0;
						ok_q    <= 1'b0;
						addr_q  <= '0;
						if (opcode == OP_ALLOC && request_bytes == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rptr_q <= rptr_q + CNTW'(1);
					end
					if (dv_s1) begin
						if (op_q == OP_ALLOC) begin
							// best fit keeps the first of equal leftovers
							if (hit_a && (!found_q || left_a < bleft_q)) begin
								found_q <= 1'b1;
								bidx_q  <= didx_s1;
								boff_q  <= e_off;
								bsize_q <= e_size;
								bleft_q <= left_a;
								if (fit_mode == FIT_FIRST) begin
									state_q <= ST_FOUND;
								end
							end
						end else begin
							if (hit_f) begin
								cur_q   <= rd_data;
								cidx_q  <= didx_s1;
								state_q <= ST_FNXT;
							end else begin
								prev_q <= rd_data;
							end
						end
					end else if (rptr_q >= count_q) begin
						state_q <= (op_q == OP_ALLOC) ? ST_FOUND : ST_DONE;
					end
				end
				ST_FOUND: begin
					if (found_q) begin
						ok_q   <= 1'b1;
						addr_q <= boff_q;
						if (split) begin
							ft_q    <= AW'(CW'(ft_q) - CW'(bsize_q) + CW'(left) - hdr_c);
							new_q   <= {AW'(CW'(boff_q) + sz_q + hdr_c),
								AW'(CW'(left) - hdr_c), 1'b1};
							rptr_q  <= count_q - CNTW'(1);
							state_q <= ST_SHUP;
						end else begin
							ft_q    <= ft_q - bsize_q;
							state_q <= ST_DONE;
						end
					end else begin
						if (append_ok) begin
							ok_q    <= 1'b1;
							addr_q  <= AW'(CW'(seg_q) + hdr_c);
							seg_q   <= AW'(CW'(seg_q) + hdr_c + sz_q);
							count_q <= count_q + CNTW'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_SHUP: begin
					if (rd_en) begin
						rptr_q <= rptr_q - CNTW'(1);
					end
					if (!rd_en && !dv_s1) begin
						state_q <= ST_WRNEW;
					end
				end
				ST_WRNEW: begin
					count_q <= count_q + CNTW'(1);
					state_q <= ST_DONE;
				end
				ST_FNXT: begin
					ft_q   <= AW'(ft_free);
					ok_q   <= 1'b1;
					d_q    <= {1'b0, nf} + {1'b0, pf};
					rptr_q <= cidx_q + CNTW'(1) + CNTW'(nf);
					if (nf || pf) begin
						state_q <= ST_SHDN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SHDN: begin
					if (rd_en) begin
						rptr_q <= rptr_q + CNTW'(1);
					end
					if (!rd_en && !dv_s1) begin
						count_q <= count_q - CNTW'(d_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat = '{idle: (state_q == ST_IDLE), res_valid: (state_q == ST_DONE),
		res_ok: ok_q};
	assign payload_address = addr_q;
	assign segment_bytes   = seg_q;
	assign free_bytes      = ft_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_BLOCKS))
		else $error("block count beyond table depth");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("read and write hit the same table entry");

	a_seg_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> seg_q >= $past(seg_q))
		else $error("segment end moved backward");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !res_take |=> state_q == ST_DONE && $stable(addr_q))
		else $error("result dropped before it was taken");
`endif
endmodule
`default_nettype wire

// ===== design/first_best_fit_heap_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_best_fit_heap_allocator
// heap allocator with first or best fit over an address-ordered block table
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid / in_stall): opcode, request_bytes, release_address;
//   each transaction gives exactly one result transaction on the output channel
//   (out_valid / out_stall): ok, payload_address, segment_bytes, free_bytes
// - configuration (cfg_valid / cfg_ready, always ready): index 0 fit_mode,
//   index 1 header_bytes; write only while no request is in flight
// - one request at a time: an allocate scans the table over N blocks, then moves
//   each later block up one entry when a block is split; a free scans until it
//   finds block i, then moves the later blocks down after a merge; the single
//   read port of the block table sets the pace of both
// - the result sits in an output register; the next request is taken while it
//   waits, and a stalled output holds its value; the engine then waits to hand
//   over the following result
// - reset empties the heap at once (block count, segment end, free total);
//   the table memory is not cleared
// ----------------------------------------------------------------------------
module first_best_fit_heap_allocator #(
	parameter int HEAP_BYTES = fbh_pkg::HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS = fbh_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [fbh_pkg::FIELD_W-1:0]       request_bytes,
	input  wire logic [fbh_pkg::FIELD_W-1:0]       release_address,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   ok,
	output logic      [fbh_pkg::FIELD_W-1:0]       payload_address,
	output logic      [fbh_pkg::FIELD_W-1:0]       segment_bytes,
	output logic      [fbh_pkg::FIELD_W-1:0]       free_bytes,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fbh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fbh_pkg::HDR_W-1:0]         cfg_data
);
	import fbh_pkg::*;

	localparam int AW = $clog2(HEAP_BYTES + 1);

	logic              fit_mode_q;
	logic [HDR_W-1:0]  header_q;
	logic [HDR_W-1:0]  hdr_eff;
	eng_stat_t         stat;
	logic              start;
	logic              res_take;
	logic [AW-1:0]     eng_addr;
	logic [AW-1:0]     eng_seg;
	logic [AW-1:0]     eng_free;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;
	assign hdr_eff   = (header_q < HDR_W'(HDR_MIN)) ? HDR_W'(HDR_MIN) : header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			header_q   <= HDR_W'(HDR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_FIT_MODE) begin
				fit_mode_q <= cfg_data[0];
			end else if (cfg_index == CFG_HEADER) begin
				header_q <= cfg_data;
			end
		end
	end

	assign in_stall = !stat.idle;
	assign start    = in_valid && !in_stall;

	fbh_engine #(
		.HEAP_BYTES (HEAP_BYTES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.opcode          (opcode),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.fit_mode        (fit_mode_q),
		.hdr             (hdr_eff),
		.res_take        (res_take),
		.stat            (stat),
		.payload_address (eng_addr),
		.segment_bytes   (eng_seg),
		.free_bytes      (eng_free)
	);

	// output register, refilled when empty or being taken
	assign res_take = stat.res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			ok              <= stat.res_ok;
			payload_address <= FIELD_W'(eng_addr);
			segment_bytes   <= FIELD_W'(eng_seg);
			free_bytes      <= FIELD_W'(eng_free);
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire
